### rtl/atbtd_pkg.sv
// Package for the ARM/Thumb branch target decode unit.
// Holds the widths, opcodes, branch kinds and the decode result struct.
// Used by every module under rtl; depends on nothing.
package atbtd_pkg;

   localparam int REG_COUNT   = 16;
   localparam int REG_IDX_W   = $clog2(REG_COUNT);
   localparam int WORD_W      = 32;
   localparam int REQ_TDATA_W = 104;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 5;

   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_WRITE  = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      KIND_NONE     = 4'd0,
      KIND_T_BLX_RM = 4'd1,
      KIND_T_BX_RM  = 4'd2,
      KIND_T_BL     = 4'd3,
      KIND_T_BLX    = 4'd4,
      KIND_A_BLX_RM = 4'd5,
      KIND_A_BX_RM  = 4'd6,
      KIND_A_BL     = 4'd7,
      KIND_A_BLX    = 4'd8
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [WORD_W-1:0]      target;
      logic [REG_IDX_W-1:0]   rm;
      logic                   rm_valid;
   } decode_type;

endpackage

### rtl/atbtd_regfile.sv
// Register snapshot of the branch target decode unit: 16 words, cleared at reset.
// One write port and one combinational read port; uses atbtd_pkg.
module atbtd_regfile (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [atbtd_pkg::REG_IDX_W-1:0]  wr_idx,
   input  logic [atbtd_pkg::WORD_W-1:0]     wr_data,
   input  logic [atbtd_pkg::REG_IDX_W-1:0]  rd_idx,
   output logic [atbtd_pkg::WORD_W-1:0]     rd_data
);
   import atbtd_pkg::*;

   logic [WORD_W-1:0] regs_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr_en) begin
         regs_ff[wr_idx] <= wr_data;
      end
   end

   assign rd_data = regs_ff[rd_idx];

endmodule

### rtl/atbtd_decode.sv
// Branch pattern decoder: classifies one ARM word or Thumb halfword pair
// and computes the immediate target. Purely combinational; uses atbtd_pkg.
module atbtd_decode (
   input  logic [atbtd_pkg::WORD_W-1:0]  instr_word,
   input  logic [atbtd_pkg::WORD_W-1:0]  pc_value,
   input  logic                          thumb_mode,
   output atbtd_pkg::decode_type         result
);
   import atbtd_pkg::*;

   logic [15:0]       first;
   logic [15:0]       second;
   logic              s_bit;
   logic              i1;
   logic              i2;
   logic [11:0]       low_bl;
   logic [11:0]       low_blx;
   logic [WORD_W-1:0] t_off_bl;
   logic [WORD_W-1:0] t_off_blx;
   logic [WORD_W-1:0] a_off;
   logic [WORD_W-1:0] t_base;
   logic [WORD_W-1:0] a_base;
   logic [WORD_W-1:0] t_bl_tgt;
   logic [WORD_W-1:0] t_blx_tgt;
   logic [WORD_W-1:0] a_bl_tgt;
   logic [WORD_W-1:0] a_blx_tgt;

   always_comb begin
      first     = instr_word[15:0];
      second    = instr_word[31:16];
      s_bit     = first[10];
      i1        = ~(second[13] ^ s_bit);
      i2        = ~(second[11] ^ s_bit);
      low_bl    = {second[10:0], 1'b0};
      low_blx   = {second[10:1], 2'b00};
      t_off_bl  = {{7{s_bit}}, s_bit, i1, i2, first[9:0], low_bl};
      t_off_blx = {{7{s_bit}}, s_bit, i1, i2, first[9:0], low_blx};
      a_off     = {{6{instr_word[23]}}, instr_word[23:0], 2'b00};
      t_base    = pc_value + 32'd4;
      a_base    = pc_value + 32'd8;
      t_bl_tgt  = (t_base + t_off_bl) | 32'd1;
      t_blx_tgt = (t_base + t_off_blx) & ~32'd3;
      a_bl_tgt  = a_base + a_off;
      a_blx_tgt = (a_base + a_off + {30'd0, instr_word[24], 1'b0}) | 32'd1;

      result = '{kind: KIND_NONE, target: '0, rm: '0, rm_valid: 1'b0};
      if (thumb_mode) begin
         priority if ((first & 16'hFF87) == 16'h4780) begin
            result.kind     = KIND_T_BLX_RM;
            result.rm       = first[6:3];
            result.rm_valid = 1'b1;
         end else if ((first & 16'hFF87) == 16'h4700) begin
            result.kind     = KIND_T_BX_RM;
            result.rm       = first[6:3];
            result.rm_valid = 1'b1;
         end else if ((first & 16'hF800) == 16'hF000) begin
            if ((second & 16'hD000) == 16'hD000) begin
               result.kind   = KIND_T_BL;
               result.target = t_bl_tgt;
            end else if ((second & 16'hD000) == 16'hC000) begin
               result.kind   = KIND_T_BLX;
               result.target = t_blx_tgt;
            end
         end else begin
            result.kind = KIND_NONE;
         end
      end else begin
         priority if ((instr_word & 32'h0FFF_FFF0) == 32'h012F_FF30) begin
            result.kind     = KIND_A_BLX_RM;
            result.rm       = instr_word[3:0];
            result.rm_valid = 1'b1;
         end else if ((instr_word & 32'h0FFF_FFF0) == 32'h012F_FF10) begin
            result.kind     = KIND_A_BX_RM;
            result.rm       = instr_word[3:0];
            result.rm_valid = 1'b1;
         end else if ((instr_word & 32'h0F00_0000) == 32'h0B00_0000
                      && instr_word[31:28] != 4'hF) begin
            result.kind   = KIND_A_BL;
            result.target = a_bl_tgt;
         end else if ((instr_word & 32'hFE00_0000) == 32'hFA00_0000) begin
            result.kind   = KIND_A_BLX;
            result.target = a_blx_tgt;
         end else begin
            result.kind = KIND_NONE;
         end
      end
   end

endmodule

### rtl/arm_thumb_branch_target_decode_unit.sv
// Top level of the ARM/Thumb branch target decode unit.
// Instantiates atbtd_decode and atbtd_regfile; uses atbtd_pkg.
//
// Channel  Dir  Handshake          Contents
// req      in   req_tvalid/tready  write item or decode item
// rsp      out  rsp_tvalid/tready  one result word per decode item
//
// An item is registered in the input register on acceptance; a decode item's result
// is then registered in the result register. One item is taken every cycle while no
// decode item waits on a stalled result; the path is one input register, one decode
// and snapshot read, one result register. A write item updates the snapshot as it
// leaves the input register and produces no word. Reset clears the snapshot and both
// valid flags. A stalled result holds the input register when that holds a decode item.
module arm_thumb_branch_target_decode_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // reg_index[3:0], reg_value[35:4], instr_word[67:36], pc_value[99:68], zero
   input  logic [atbtd_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // opcode[0], thumb_mode[1]
   input  logic [atbtd_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // target_addr[31:0], src_reg[35:32], zero
   output logic [atbtd_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // br_kind[3:0], src_reg_valid[4]
   output logic [atbtd_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);
   import atbtd_pkg::*;

   logic                   s1_valid_ff;
   opcode_type             s1_op_ff;
   logic [REG_IDX_W-1:0]   s1_idx_ff;
   logic [WORD_W-1:0]      s1_value_ff;
   logic [WORD_W-1:0]      s1_word_ff;
   logic [WORD_W-1:0]      s1_pc_ff;
   logic                   s1_thumb_ff;

   logic                   rsp_valid_ff;
   kind_type               rsp_kind_ff;
   logic [WORD_W-1:0]      rsp_target_ff;
   logic [REG_IDX_W-1:0]   rsp_rm_ff;
   logic                   rsp_rm_valid_ff;

   logic                   req_fire;
   logic                   s1_adv;
   logic                   s1_is_write;
   logic                   out_load;
   decode_type             dec;
   logic [WORD_W-1:0]      rd_data;
   logic [WORD_W-1:0]      target_in;

   assign s1_is_write = s1_valid_ff && (s1_op_ff == OP_WRITE);
   assign s1_adv      = s1_valid_ff && (s1_is_write || !rsp_valid_ff || rsp_tready);
   assign out_load    = s1_adv && !s1_is_write;
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign req_fire    = req_tvalid && req_tready;

   atbtd_decode u_decode (
      .instr_word (s1_word_ff),
      .pc_value   (s1_pc_ff),
      .thumb_mode (s1_thumb_ff),
      .result     (dec)
   );

   atbtd_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s1_adv && s1_is_write),
      .wr_idx  (s1_idx_ff),
      .wr_data (s1_value_ff),
      .rd_idx  (dec.rm),
      .rd_data (rd_data)
   );

   assign target_in = dec.rm_valid ? rd_data : dec.target;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= opcode_type'(req_tuser[0]);
         s1_thumb_ff <= req_tuser[1];
         s1_idx_ff   <= req_tdata[3:0];
         s1_value_ff <= req_tdata[35:4];
         s1_word_ff  <= req_tdata[67:36];
         s1_pc_ff    <= req_tdata[99:68];
      end
      if (out_load) begin
         rsp_kind_ff     <= dec.kind;
         rsp_target_ff   <= target_in;
         rsp_rm_ff       <= dec.rm;
         rsp_rm_valid_ff <= dec.rm_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_rm_ff, rsp_target_ff};
   assign rsp_tuser  = {rsp_rm_valid_ff, rsp_kind_ff};

   a_reg_valid_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rm_valid_ff |->
         (rsp_kind_ff == KIND_T_BLX_RM || rsp_kind_ff == KIND_T_BX_RM ||
          rsp_kind_ff == KIND_A_BLX_RM || rsp_kind_ff == KIND_A_BX_RM))
      else $error("Register source flagged for an immediate or empty kind.");

   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_NONE |->
         (rsp_target_ff == '0 && rsp_rm_ff == '0 && !rsp_rm_valid_ff))
      else $error("A result without a branch carries nonzero fields.");

   a_thumb_bits : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_T_BL || rsp_kind_ff == KIND_A_BLX) |->
         rsp_target_ff[0])
      else $error("A branch with link into Thumb lost the low target bit.");

   a_decode_hold : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_word_ff))
      else $error("A stalled decode item left the input register.");

endmodule
